// File: rtl/paps_pkg.sv
// package for the phase accumulator polynomial sine oscillator
// holds controller states, datapath command and status types, coefficients
// depends on nothing
package paps_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned PROD_W = 2 * DATA_W;

    localparam logic signed [DATA_W-1:0] COEF_A = 16'sd25718;
    localparam logic signed [DATA_W-1:0] COEF_B = -16'sd20953;
    localparam logic signed [DATA_W-1:0] COEF_C = 16'sd18276;

    localparam logic signed [DATA_W-1:0] QUARTER_TURN = 16'sd16384;
    localparam logic signed [DATA_W-1:0] POS_FULL     = 16'sd32767;
    localparam logic signed [DATA_W-1:0] NEG_FULL     = -16'sd32767;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 1'd1;

    localparam logic [DATA_W-1:0] RUN_LENGTH_RESET = 16'd1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_XA,
        ST_MUL_XSQX,
        ST_WAIT_XCU,
        ST_MUL_XCUXSQ,
        ST_MUL_XCUB,
        ST_MUL_X5C,
        ST_WR_TC,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        MUL_X_X,
        MUL_X_A,
        MUL_XSQ_X,
        MUL_XCU_XSQ,
        MUL_XCU_B,
        MUL_X5_C
    } mul_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_XSQ,
        WR_TA,
        WR_XCU,
        WR_X5,
        WR_TB,
        WR_TC
    } wr_sel_t;

    typedef struct packed {
        logic     start;
        mul_sel_t mul_sel;
        wr_sel_t  wr_sel;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/paps_ctrl.sv
// controller state machine for the polynomial sine oscillator
// sequences the shared multiplier and drives the datapath commands
// depends on paps_pkg
module paps_ctrl
    import paps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL_XX;
                end
            end
            ST_MUL_XX:     state_next = ST_MUL_XA;
            ST_MUL_XA:     state_next = ST_MUL_XSQX;
            ST_MUL_XSQX:   state_next = ST_WAIT_XCU;
            ST_WAIT_XCU:   state_next = ST_MUL_XCUXSQ;
            ST_MUL_XCUXSQ: state_next = ST_MUL_XCUB;
            ST_MUL_XCUB:   state_next = ST_MUL_X5C;
            ST_MUL_X5C:    state_next = ST_WR_TC;
            ST_WR_TC:      state_next = ST_FINISH;
            ST_FINISH: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.start    = 1'b0;
        cmd.mul_sel  = MUL_X_X;
        cmd.wr_sel   = WR_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_MUL_XX: begin
                cmd.mul_sel = MUL_X_X;
            end
            ST_MUL_XA: begin
                cmd.mul_sel = MUL_X_A;
                cmd.wr_sel  = WR_XSQ;
            end
            ST_MUL_XSQX: begin
                cmd.mul_sel = MUL_XSQ_X;
                cmd.wr_sel  = WR_TA;
            end
            ST_WAIT_XCU: begin
                cmd.wr_sel = WR_XCU;
            end
            ST_MUL_XCUXSQ: begin
                cmd.mul_sel = MUL_XCU_XSQ;
            end
            ST_MUL_XCUB: begin
                cmd.mul_sel = MUL_XCU_B;
                cmd.wr_sel  = WR_X5;
            end
            ST_MUL_X5C: begin
                cmd.mul_sel = MUL_X5_C;
                cmd.wr_sel  = WR_TB;
            end
            ST_WR_TC: begin
                cmd.wr_sel = WR_TC;
            end
            ST_FINISH: begin
                cmd.load_out = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/paps_dp.sv
// datapath for the polynomial sine oscillator
// phase accumulator, quarter-wave fold, shared multiplier, output register
// depends on paps_pkg
module paps_dp
    import paps_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_wdata,
    input  logic                        s_restart,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_sample,
    output logic                        m_last
);

    logic [DATA_W-1:0]        phase_step_reg, run_length_reg;
    logic [DATA_W-1:0]        phase_reg, phase_next;
    logic [DATA_W-1:0]        index_reg, index_next;
    logic                     last_reg;
    logic signed [DATA_W-1:0] x_reg, xsq_reg, xcu_reg, x5_reg;
    logic signed [DATA_W-1:0] ta_reg, tb_reg, tc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_sample_reg;
    logic                     m_last_reg;

    logic [DATA_W-1:0]        phase_eff, index_eff;
    logic                     last_now;
    logic signed [DATA_W-1:0] x_fold;
    logic signed [DATA_W-1:0] op_a, op_b;
    logic signed [DATA_W-1:0] prod_hi;
    logic signed [DATA_W-1:0] sum;

    function automatic logic signed [DATA_W-1:0] fold(input logic signed [DATA_W-1:0] p);
        logic signed [DATA_W-1:0] d;
        d = '0;
        if (p == QUARTER_TURN) begin
            fold = POS_FULL;
        end else if (p < QUARTER_TURN && p > -QUARTER_TURN) begin
            fold = {p[DATA_W-2:0], 1'b0};
        end else if (p > QUARTER_TURN && p != POS_FULL) begin
            d    = POS_FULL - p;
            fold = {d[DATA_W-2:0], 1'b0};
        end else begin
            d    = NEG_FULL - p;
            fold = {d[DATA_W-2:0], 1'b0};
        end
    endfunction

    // accept-time state update
    always_comb begin
        phase_eff  = s_restart ? '0 : phase_reg;
        index_eff  = s_restart ? '0 : index_reg;
        last_now   = ({1'b0, index_eff} + 17'd1) >= {1'b0, run_length_reg};
        phase_next = last_now ? '0 : phase_eff + phase_step_reg;
        index_next = last_now ? '0 : index_eff + 16'd1;
        x_fold     = fold(phase_eff);
    end

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_X_X:     begin op_a = x_reg;   op_b = x_reg;   end
            MUL_X_A:     begin op_a = x_reg;   op_b = COEF_A;  end
            MUL_XSQ_X:   begin op_a = xsq_reg; op_b = x_reg;   end
            MUL_XCU_XSQ: begin op_a = xcu_reg; op_b = xsq_reg; end
            MUL_XCU_B:   begin op_a = xcu_reg; op_b = COEF_B;  end
            MUL_X5_C:    begin op_a = x5_reg;  op_b = COEF_C;  end
            default:     begin op_a = x_reg;   op_b = x_reg;   end
        endcase
    end

    assign prod_hi = prod_reg[PROD_W-1:DATA_W];
    assign sum     = tc_reg + tb_reg + ta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            run_length_reg <= RUN_LENGTH_RESET;
            phase_reg      <= '0;
            index_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                    CFG_RUN_LENGTH: run_length_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.start) begin
                phase_reg <= phase_next;
                index_reg <= index_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (cmd.start) begin
            x_reg    <= x_fold;
            last_reg <= last_now;
        end
        case (cmd.wr_sel)
            WR_XSQ:  xsq_reg <= {prod_hi[DATA_W-2:0], 1'b0};
            WR_TA:   ta_reg  <= {prod_hi[DATA_W-2:0], 1'b0};
            WR_XCU:  xcu_reg <= {prod_hi[DATA_W-2:0], 1'b0};
            WR_X5:   x5_reg  <= {prod_hi[DATA_W-2:0], 1'b0};
            WR_TB:   tb_reg  <= prod_hi;
            WR_TC:   tc_reg  <= prod_hi >>> 3;
            default: ;
        endcase
        if (cmd.load_out) begin
            m_sample_reg <= {sum[DATA_W-2:0], 1'b0};
            m_last_reg   <= last_reg;
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_sample        = m_sample_reg;
    assign m_last          = m_last_reg;

endmodule

// File: rtl/phase_accumulator_poly_sine_top.sv
// top level of the q15 polynomial sine oscillator
// joins the controller paps_ctrl and the datapath paps_dp
// depends on paps_pkg
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_restart
//  m_       out        m_valid/m_ready    m_sample, m_last
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// a new beat is taken only once the last one is through: one multiplier is
// shared by six dependent products, each registered before use
// aresetn synchronous, active low: phase, index, config and output valid to reset values
// a stalled output beat holds the finished item; the next beat is then
// taken but its result waits in the datapath until the output frees
module phase_accumulator_poly_sine_top
    import paps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_restart,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_sample,
    output logic                     m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    paps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    paps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_restart (s_restart),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (m_sample),
        .m_last    (m_last)
    );

endmodule

// File: dv/phase_accumulator_poly_sine_top_tb.sv
`timescale 1ns / 100ps
// testbench for phase_accumulator_poly_sine_top: drives restart beats, writes step and
// run length between phases, and predicts each sample and last flag in a scoreboard class
// depends on paps_pkg and the rtl of the oscillator
module phase_accumulator_poly_sine_top_tb
    import paps_pkg::*;
();

    localparam int TOTAL_ITEMS = 1150;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_MAX    = 12;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } sine_beat_t;

    class sine_scoreboard;
        logic [DATA_W-1:0] phase_acc;
        logic [DATA_W-1:0] run_pos;
        logic [DATA_W-1:0] step_reg;
        logic [DATA_W-1:0] run_len_reg;
        sine_beat_t        expected_q[$];
        int                errors;

        function new();
            phase_acc   = '0;
            run_pos     = '0;
            step_reg    = '0;
            run_len_reg = RUN_LENGTH_RESET;
            errors      = 0;
        endfunction

        function int wrap16(int v);
            logic signed [15:0] t;
            t = v[15:0];
            return int'(t);
        endfunction

        function int mul_high(int a, int b);
            int prod;
            prod = a * b;
            return wrap16(prod >>> 16);
        endfunction

        function logic signed [DATA_W-1:0] sine_q15(logic [DATA_W-1:0] ph);
            int p, x, sq, cu, x5, ta, tb, tc, acc;
            p = wrap16(int'(ph));
            // fold into a quarter wave, all in 16-bit wrapping arithmetic
            if (p == int'(QUARTER_TURN)) begin
                x = int'(POS_FULL);
            end else if (p < int'(QUARTER_TURN) && p > -int'(QUARTER_TURN)) begin
                x = wrap16(p << 1);
            end else if (p > int'(QUARTER_TURN) && p < int'(POS_FULL)) begin
                x = wrap16((int'(POS_FULL) - p) << 1);
            end else begin
                x = wrap16((int'(NEG_FULL) - p) << 1);
            end
            sq  = wrap16(mul_high(x, x) << 1);
            cu  = wrap16(mul_high(sq, x) << 1);
            x5  = wrap16(mul_high(cu, sq) << 1);
            ta  = wrap16(mul_high(x, int'(COEF_A)) << 1);
            tb  = mul_high(cu, int'(COEF_B));
            tc  = mul_high(x5, int'(COEF_C)) >>> 3;
            acc = wrap16(tc + tb);
            acc = wrap16(acc + ta);
            return DATA_W'(acc << 1);
        endfunction

        function void note_input(logic restart);
            sine_beat_t e;
            if (restart) begin
                phase_acc = '0;
                run_pos   = '0;
            end
            e.sample = sine_q15(phase_acc);
            e.last   = (int'(run_pos) + 1 >= int'(run_len_reg));
            expected_q.push_back(e);
            if (e.last) begin
                phase_acc = '0;
                run_pos   = '0;
            end else begin
                phase_acc = phase_acc + step_reg;
                run_pos   = run_pos + 16'd1;
            end
        endfunction

        task report(string msg);
            $display("%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [DATA_W-1:0] sample, logic last);
            sine_beat_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected beat: sample %0d last %0b", sample, last));
                return;
            end
            e = expected_q.pop_front();
            if (sample !== e.sample)
                report($sformatf("sample mismatch: got %0d, want %0d", sample, e.sample));
            if (last !== e.last)
                report($sformatf("last mismatch: got %0b, want %0b", last, e.last));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_restart;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_sample;
    logic                     m_last;

    sine_scoreboard sb = new();
    int             tx_gap_max = IDLE_MAX;
    int             rx_gap_max = IDLE_MAX;
    bit             hold_off_req = 0;
    int             items_sent = 0;

    phase_accumulator_poly_sine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (m_sample),
        .m_last    (m_last)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_item(logic restart);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(restart);
        items_sent++;
    endtask

    task automatic wait_drain();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(logic [DATA_W-1:0] step, logic [DATA_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PHASE_STEP;
        cfg_wdata <= step;
        @(posedge aclk);
        cfg_index <= CFG_RUN_LENGTH;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.step_reg    = step;
        sb.run_len_reg = len;
    endtask

    task automatic run_batch(int n, logic [31:0] restart_mask, int restart_pct, int pause_at);
        logic r;
        for (int i = 0; i < n; i++) begin
            r = ((i < 32) ? restart_mask[i] : 1'b0) | ($urandom_range(1, 100) <= restart_pct);
            if (i == pause_at) begin
                // sender holds back until every sample is home
                s_valid <= 1'b0;
                wait_drain();
            end
            send_item(r);
        end
        s_valid <= 1'b0;
        wait_drain();
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = hold_off_req ? HOLD_CYCLES : $urandom_range(0, rx_gap_max);
            hold_off_req = 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_sample, m_last);
        end
    end

    initial begin
        int               phase_no;
        int               n;
        int               pause_at;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] len;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PHASE_STEP;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, quarter-turn and half-turn phases, phase 32767,
        // zero run length, run length lowered mid-run, restart, extreme registers
        run_batch(2, 32'h1, 0, -1);
        write_config(16'h4000, 16'd1024);
        run_batch(4, 32'h0, 0, -1);
        write_config(16'h7fff, 16'd1024);
        run_batch(3, 32'h0, 0, -1);
        write_config(16'h8000, 16'd0);
        run_batch(3, 32'h0, 0, -1);
        write_config(16'd12345, 16'd1000);
        run_batch(6, 32'h0, 0, -1);
        write_config(16'd12345, 16'd3);
        run_batch(3, 32'h4, 0, -1);
        write_config(16'h0001, 16'hffff);
        run_batch(2, 32'h0, 0, -1);
        write_config(16'hffff, 16'd1);
        run_batch(2, 32'h0, 0, -1);

        phase_no = 0;
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       step = 16'h8000;
                1:       step = 16'h7fff;
                2:       step = 16'h4000;
                3:       step = 16'h0000;
                default: step = DATA_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       len = 16'd0;
                1:       len = 16'd1;
                2:       len = 16'hffff;
                3:       len = DATA_W'($urandom_range(2, 8));
                default: len = DATA_W'($urandom_range(9, 120));
            endcase
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            n        = $urandom_range(20, 80);
            pause_at = -1;
            if (phase_no == 2) begin
                // receiver stalls while the sender keeps offering beats
                tx_gap_max   = 0;
                hold_off_req = 1;
            end
            if (phase_no == 4)
                pause_at = n / 2;
            write_config(step, len);
            run_batch(n, 32'h0, 6, pause_at);
            phase_no++;
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: phase_accumulator_poly_sine_top.f
rtl/paps_pkg.sv
rtl/paps_ctrl.sv
rtl/paps_dp.sv
rtl/phase_accumulator_poly_sine_top.sv
dv/phase_accumulator_poly_sine_top_tb.sv
